### src/elbpid_pkg.sv
// Shared types, constants and the exponent table builder for the particle ID block.
package elbpid_pkg;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned TERM_W     = 46;
  localparam int unsigned EDGE_SUM_W = TERM_W + 1;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LO_AMP0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LO_RATE0 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LO_AMP1  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LO_RATE1 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HI_AMP0  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HI_RATE0 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HI_AMP1  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HI_RATE1 = 4'd7;

  typedef struct packed {
    logic [15:0] total_energy;
    logic [15:0] energy_loss;
  } hit_t;

  typedef struct packed {
    logic               in_proton_band;
    logic               in_pion_region;
    logic signed [31:0] band_offset;
  } pid_t;

  // 2^(i/2^tb) in Q.30, built with a 16-term series of exp(i*ln2/2^tb)
  function automatic logic [31:0] rom_entry(input int unsigned i, input int unsigned tb);
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    a    = (64'(i) * 64'(LN2_Q30)) >> tb;
    sum  = 64'(ONE_Q30);
    term = 64'(ONE_Q30);
    for (int k = 1; k <= 15; k++) begin
      term = ((term * a) >> 30) / 64'(k);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

endpackage

### src/elbpid_exp_term.sv
// Seven-stage pipeline computing amp * exp(energy * rate) in Q16.16.
module elbpid_exp_term #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [15:0]                        te_i,
  input  logic signed [31:0]                 amp_i,
  input  logic signed [31:0]                 rate_i,
  output logic signed [elbpid_pkg::TERM_W-1:0] term_o
);
  import elbpid_pkg::*;

  localparam int unsigned TB    = EXP_TABLE_BITS;
  localparam int unsigned DEPTH = 2 ** TB;
  localparam int unsigned R_W   = 30 - TB;

  logic [31:0] rom [DEPTH];
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
    localparam logic [31:0] ENTRY = rom_entry(gi, TB);
    assign rom[gi] = ENTRY;
  end

  // stage 1: product of energy and rate
  logic signed [48:0] x_q;
  // stage 2: scaled by log2(e)
  logic signed [61:0] y_q;
  // stage 3
  logic [31:0]        mant3_q;
  logic [29:0]        u_q;
  logic signed [6:0]  n3_q;
  // stage 4
  logic [31:0]        mant4_q;
  logic [31:0]        poly_q;
  logic signed [6:0]  n4_q;
  // stage 5
  logic [32:0]        m_q;
  logic signed [6:0]  n5_q;
  // stage 6
  logic signed [65:0] p_q;
  logic signed [6:0]  n6_q;
  // stage 7
  logic signed [TERM_W-1:0] term_q;

  logic signed [48:0] x_c;
  logic signed [29:0] x24;
  logic signed [61:0] y_d;
  logic [TB-1:0]      idx;
  logic [R_W-1:0]     r30;
  logic [R_W+29:0]    ur_prod;
  logic [59:0]        uu_prod;
  logic [31:0]        poly_d;
  logic [63:0]        mp_prod;
  logic signed [65:0] p_d;
  logic [5:0]         shamt;
  logic signed [65:0] shifted;

  always_comb begin
    // clamp the exponent to [-16, +8] in Q.32
    if (x_q > 49'sd34359738368) begin
      x_c = 49'sd34359738368;
    end else if (x_q < -49'sd68719476736) begin
      x_c = -49'sd68719476736;
    end else begin
      x_c = x_q;
    end
    x24 = 30'(x_c >>> 8);
    y_d = 62'(x24 * $signed({1'b0, LOG2E_Q30}));

    idx     = y_q[53 -: TB];
    r30     = y_q[53-TB:24];
    ur_prod = (R_W+30)'(r30) * (R_W+30)'(LN2_Q30);

    uu_prod = 60'(u_q) * 60'(u_q);
    poly_d  = ONE_Q30 + 32'(u_q) + 32'(uu_prod >> 31);

    mp_prod = 64'(mant4_q) * 64'(poly_q);

    p_d = 66'(amp_i * $signed({1'b0, m_q}));

    shamt   = 6'(7'sd30 - n6_q);
    shifted = p_q >>> shamt;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= $signed({1'b0, te_i}) * rate_i;
      y_q     <= y_d;
      mant3_q <= rom[idx];
      u_q     <= 30'(ur_prod >> 30);
      n3_q    <= y_q[60:54];
      mant4_q <= mant3_q;
      poly_q  <= poly_d;
      n4_q    <= n3_q;
      m_q     <= mp_prod[62:30];
      n5_q    <= n4_q;
      p_q     <= p_d;
      n6_q    <= n5_q;
      term_q  <= shifted[TERM_W-1:0];
    end
  end

  assign term_o = term_q;

endmodule

### src/energy_loss_band_particle_id.sv
// Top level of the energy-loss band particle identification block.
// Each accepted item (total energy, energy loss) yields exactly one result
// item at the end of the pipeline; a new item can be taken every cycle
// unless the output stalls. Four exponential units run side by side,
// each a seven-stage pipeline (energy*rate product, log2(e) scaling, table
// lookup with a second-order correction, mantissa product, amplitude
// product, binary scaling); one stage then sums and saturates the lower and
// upper band edges, and a last stage compares the loss against the edges and
// forms the offset from the band center. The whole pipeline advances as one
// unit: it moves whenever the output register is empty or its item is being
// taken, so a stall on the output holds every stage in place and nothing is
// lost or repeated. Coefficients are written through a plain write port
// (index 0..7; other indexes are ignored) and must only change while no item
// is in flight. The exponent table holds 2^EXP_TABLE_BITS entries.
module energy_loss_band_particle_id #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [elbpid_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [elbpid_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  elbpid_pkg::hit_t                     in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output elbpid_pkg::pid_t                     out_data_o
);
  import elbpid_pkg::*;

  localparam int unsigned TERM_STAGES = 7;
  localparam int unsigned STAGES      = TERM_STAGES + 2;

  logic [REG_W-1:0] regs_q [NUM_REGS];
  logic [STAGES-1:0] vld_q;
  logic advance;

  // Hold everything while the output item waits
  assign advance    = !vld_q[STAGES-1] || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  // Valid bits ride along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  // Four exponential terms: lower first/second, upper first/second
  logic signed [TERM_W-1:0] term [4];
  for (genvar g = 0; g < 4; g++) begin : g_term
    elbpid_exp_term #(
      .EXP_TABLE_BITS(EXP_TABLE_BITS)
    ) u_term (
      .clk_i  (clk_i),
      .en_i   (advance),
      .te_i   (in_data_i.total_energy),
      .amp_i  ($signed(regs_q[2*g])),
      .rate_i ($signed(regs_q[2*g+1])),
      .term_o (term[g])
    );
  end

  // Carry the loss alongside the term pipelines
  logic [15:0] loss_pipe_q [TERM_STAGES+1];
  always_ff @(posedge clk_i) begin
    if (advance) begin
      loss_pipe_q[0] <= in_data_i.energy_loss;
      for (int i = 1; i <= TERM_STAGES; i++) begin
        loss_pipe_q[i] <= loss_pipe_q[i-1];
      end
    end
  end

  // Edge stage: sum and saturate
  logic signed [EDGE_SUM_W-1:0] lo_sum, hi_sum;
  logic signed [31:0] lo_d, hi_d, lo_q, hi_q;

  function automatic logic signed [31:0] sat_edge(input logic signed [EDGE_SUM_W-1:0] v);
    if (v > EDGE_SUM_W'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (v < -EDGE_SUM_W'(64'sd2147483648)) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  always_comb begin
    lo_sum = EDGE_SUM_W'(term[0]) + EDGE_SUM_W'(term[1]);
    hi_sum = EDGE_SUM_W'(term[2]) + EDGE_SUM_W'(term[3]);
    lo_d   = sat_edge(lo_sum);
    hi_d   = sat_edge(hi_sum);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Output stage: flags and offset from the band center
  logic signed [32:0] loss_q16;
  logic signed [32:0] center;
  logic signed [33:0] off_raw;
  pid_t out_d, out_q;

  always_comb begin
    loss_q16 = $signed({1'b0, loss_pipe_q[TERM_STAGES], 8'd0});
    center   = (33'(lo_q) + 33'(hi_q)) >>> 1;
    off_raw  = 34'(loss_q16) - 34'(center);
    out_d.in_proton_band = (loss_q16 >= 33'(lo_q)) && (loss_q16 <= 33'(hi_q));
    out_d.in_pion_region = (loss_pipe_q[TERM_STAGES] != 16'd0) && (loss_q16 < 33'(lo_q));
    if (off_raw > 34'sd2147483647) begin
      out_d.band_offset = 32'sh7fffffff;
    end else if (off_raw < -34'sd2147483648) begin
      out_d.band_offset = 32'sh80000000;
    end else begin
      out_d.band_offset = off_raw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[STAGES-1];
  assign out_data_o  = out_q;

endmodule

### src/elbpid_checker.sv
// Port-level checks for the particle ID block, bound to the top level.
module elbpid_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input elbpid_pkg::pid_t out_data_o
);
  import elbpid_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result item changed while stalled");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output drain");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.in_proton_band && out_data_o.in_pion_region))
    else $error("proton and pion flags both set");

endmodule

bind energy_loss_band_particle_id elbpid_checker u_elbpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
